### rtl/core/lrsd_pkg.sv
// Package for the luma row seam detector: configuration codes, geometry limits,
// the state encoding of the packet tracker resync sequencer and small helpers.
// Has no dependencies; the RTL refers to it by scoped names, the testbench imports it.
package lrsd_pkg;

    // Geometry limits and register reset values.
    localparam int unsigned MaxWidth      = 1024;
    localparam int unsigned MaxHeight     = 1024;
    localparam int unsigned MinWidth      = 2;
    localparam int unsigned MinHeight     = 1;
    localparam int unsigned MinPayload    = 8;
    localparam int unsigned MaxPayload    = 4096;
    localparam int unsigned ResetWidth    = 320;
    localparam int unsigned ResetHeight   = 240;
    localparam int unsigned ResetThresh   = 50;
    localparam int unsigned ResetPayload  = 788;

    // Packet boundary window and the range of boundary multiples checked.
    localparam int unsigned BoundarySlack = 3;
    localparam int unsigned PacketLimit   = 200;
    localparam int unsigned PacketMax     = PacketLimit - 1;

    // Field widths.
    localparam int unsigned LumaWidth     = 8;
    localparam int unsigned CoordWidth    = 10;
    localparam int unsigned GeomWidth     = 11;
    localparam int unsigned PayloadWidth  = 13;
    localparam int unsigned RemWidth      = 12;
    localparam int unsigned QuotWidth     = 18;
    localparam int unsigned BytePosWidth  = 21;
    localparam int unsigned PacketWidth   = 8;
    localparam int unsigned CountWidth    = 11;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 13;

    // The restoring divider retires one quotient bit per cycle.
    localparam int unsigned DivSteps      = BytePosWidth;
    localparam int unsigned DivCountWidth = $clog2(DivSteps);

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_JUMP_THRESHOLD = 2'd2,
        CFG_PACKET_PAYLOAD = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_LOAD,
        RS_DIV
    } rs_state_t;

    typedef struct packed {
        logic [RemWidth-1:0] rem;
        logic                qbit;
    } div_step_t;

    function automatic logic [GeomWidth-1:0] clamp_width(input logic [GeomWidth-1:0] v);
        logic [GeomWidth-1:0] r;
        r = v;
        if (v < GeomWidth'(MinWidth)) begin
            r = GeomWidth'(MinWidth);
        end else if (v > GeomWidth'(MaxWidth)) begin
            r = GeomWidth'(MaxWidth);
        end
        return r;
    endfunction

    function automatic logic [GeomWidth-1:0] clamp_height(input logic [GeomWidth-1:0] v);
        logic [GeomWidth-1:0] r;
        r = v;
        if (v < GeomWidth'(MinHeight)) begin
            r = GeomWidth'(MinHeight);
        end else if (v > GeomWidth'(MaxHeight)) begin
            r = GeomWidth'(MaxHeight);
        end
        return r;
    endfunction

    function automatic logic [PayloadWidth-1:0] clamp_payload(
        input logic [PayloadWidth-1:0] v
    );
        logic [PayloadWidth-1:0] r;
        r = v;
        if (v < PayloadWidth'(MinPayload)) begin
            r = PayloadWidth'(MinPayload);
        end else if (v > PayloadWidth'(MaxPayload)) begin
            r = PayloadWidth'(MaxPayload);
        end
        return r;
    endfunction

    // One step of a restoring division: shift in the next dividend bit and
    // subtract the divisor when it fits. The remainder stays below the divisor.
    function automatic div_step_t div_step(
        input logic [RemWidth-1:0]     rem,
        input logic                    dbit,
        input logic [PayloadWidth-1:0] divisor
    );
        div_step_t            s;
        logic [RemWidth:0]    t;
        t = {rem, dbit};
        if (t >= divisor) begin
            s.rem  = RemWidth'(t - divisor);
            s.qbit = 1'b1;
        end else begin
            s.rem  = t[RemWidth-1:0];
            s.qbit = 1'b0;
        end
        return s;
    endfunction

endpackage

### rtl/core/luma_row_seam_detector_unit.sv
// Luma row seam detector, top level: input register, single-pass row logic,
// result register and the packet tracker resync divider.
// Depends on lrsd_pkg.
//
// Usage. Pixels arrive in raster order on the input channel (luma, frame_start),
// one transfer per pixel; frame_start marks the first pixel of a frame. After the
// last pixel of each row one result transfer leaves on the output channel with
// the row, the first column of its largest even-column luma jump, the byte
// position of that pixel, the jump, the seam flag, the packet boundary match and
// the running seam count. Both channels transfer when valid is high and stall
// is low. Registers are written through the cfg port, one per transfer; the user
// must write them only while the block is idle; the block does not enforce it.
// cfg_ready is always high. An input transfer fills the input register and its
// row result goes to the result register. Unless stalled or resyncing, the block
// takes one pixel per cycle: the input register is refilled in the same cycle it
// drains. The packet number of each pixel is tracked as a running quotient and
// remainder, advanced by two bytes per pixel. A write to the width or payload
// register, and a row that ends past a shrunken width, restart that tracker with
// a 21-step restoring divider: input processing pauses while one more pixel can
// still be buffered in the input register. When the receiver stalls, the result
// register holds its item and the input side stalls as soon as a further row end
// would need that register. Reset clears the counters and loads the register
// defaults (320 x 240, threshold 50, payload 788).

module luma_row_seam_detector_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lrsd_pkg::LumaWidth-1:0]       luma,
    input  logic                                 frame_start,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lrsd_pkg::CoordWidth-1:0]      row_index,
    output logic [lrsd_pkg::CoordWidth-1:0]      seam_col,
    output logic [lrsd_pkg::BytePosWidth-1:0]    byte_position,
    output logic [lrsd_pkg::LumaWidth-1:0]       max_jump,
    output logic                                 is_seam,
    output logic                                 on_packet_boundary,
    output logic [lrsd_pkg::PacketWidth-1:0]     packet_number,
    output logic [lrsd_pkg::CountWidth-1:0]      seam_count,
    output logic                                 frame_last,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lrsd_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [lrsd_pkg::CfgDataWidth-1:0]    cfg_data
);

    localparam int unsigned LW  = lrsd_pkg::LumaWidth;
    localparam int unsigned CW  = lrsd_pkg::CoordWidth;
    localparam int unsigned GW  = lrsd_pkg::GeomWidth;
    localparam int unsigned PW  = lrsd_pkg::PayloadWidth;
    localparam int unsigned RW  = lrsd_pkg::RemWidth;
    localparam int unsigned QW  = lrsd_pkg::QuotWidth;
    localparam int unsigned BW  = lrsd_pkg::BytePosWidth;
    localparam int unsigned KW  = lrsd_pkg::PacketWidth;
    localparam int unsigned SW  = lrsd_pkg::CountWidth;
    localparam int unsigned DCW = lrsd_pkg::DivCountWidth;

    // Configuration registers.
    logic [GW-1:0] frame_width_reg;
    logic [GW-1:0] frame_height_reg;
    logic [LW-1:0] jump_threshold_reg;
    logic [PW-1:0] packet_payload_reg;

    // Input register.
    logic          in_valid_reg, in_valid_next;
    logic [LW-1:0] in_luma_reg;
    logic          in_start_reg;

    // Row state.
    logic [LW-1:0] prev_luma_reg, prev_luma_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [LW-1:0] best_jump_reg, best_jump_next;
    logic [CW-1:0] best_col_reg, best_col_next;
    logic [SW-1:0] seam_total_reg, seam_total_next;

    // Packet tracker: quotient and remainder of the byte position by the
    // payload, for the next pixel and for the best pixel of the row.
    logic [QW-1:0] pix_q_reg, pix_q_next;
    logic [RW-1:0] pix_r_reg, pix_r_next;
    logic [QW-1:0] best_q_reg, best_q_next;
    logic [RW-1:0] best_r_reg, best_r_next;

    // Resync divider.
    lrsd_pkg::rs_state_t rs_state_reg, rs_state_next;
    logic [DCW-1:0]      div_count_reg, div_count_next;
    logic [BW-1:0]       pix_dvd_reg, pix_dvd_next;
    logic [BW-1:0]       best_dvd_reg, best_dvd_next;
    logic [RW-1:0]       pix_rem_reg, pix_rem_next;
    logic [RW-1:0]       best_rem_reg, best_rem_next;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] row_index_reg;
    logic [CW-1:0] seam_col_reg;
    logic [BW-1:0] byte_position_reg;
    logic [LW-1:0] max_jump_reg;
    logic          is_seam_reg;
    logic          on_boundary_reg;
    logic [KW-1:0] packet_number_reg;
    logic [SW-1:0] seam_count_reg;
    logic          frame_last_reg;

    // Combinational row logic.
    logic [GW-1:0] w;
    logic [GW-1:0] h;
    logic [PW-1:0] pay;
    logic [CW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic [LW-1:0] cur_best_jump;
    logic [CW-1:0] cur_best_col;
    logic [SW-1:0] cur_seam_total;
    logic [QW-1:0] cur_pq;
    logic [RW-1:0] cur_pr;
    logic [QW-1:0] cur_bq;
    logic [RW-1:0] cur_br;
    logic [LW-1:0] diff;
    logic          take;
    logic [LW-1:0] upd_jump;
    logic [CW-1:0] upd_col;
    logic [QW-1:0] upd_bq;
    logic [RW-1:0] upd_br;
    logic [PW-1:0] r_plus;
    logic          wrap;
    logic [QW-1:0] step_q;
    logic [RW-1:0] step_r;
    logic [GW-1:0] col_ext;
    logic          row_end;
    logic          row_regular;
    logic          last;
    logic          seam;
    logic [BW-1:0] prod;
    logic [BW-1:0] pos_sum;
    logic [BW-1:0] bp;
    logic [PW-1:0] gap;
    logic          match_low;
    logic          match_high;
    logic [KW-1:0] pkt;
    logic [SW-1:0] seam_total_upd;
    logic          out_room;
    logic          proceed;
    logic          accept;
    logic          cfg_write;
    logic          resync;

    // Resync datapath.
    logic [BW-1:0]       load_prod;
    logic [BW-1:0]       load_pix_sum;
    logic [BW-1:0]       load_best_sum;
    lrsd_pkg::div_step_t pix_st;
    lrsd_pkg::div_step_t best_st;
    logic [BW-1:0]       pix_dvd_shift;
    logic [BW-1:0]       best_dvd_shift;
    logic                div_done;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= GW'(lrsd_pkg::ResetWidth);
            frame_height_reg   <= GW'(lrsd_pkg::ResetHeight);
            jump_threshold_reg <= LW'(lrsd_pkg::ResetThresh);
            packet_payload_reg <= PW'(lrsd_pkg::ResetPayload);
        end
        else if (cfg_write)
        begin
            case (lrsd_pkg::cfg_reg_t'(cfg_index))
                lrsd_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[GW-1:0];
                lrsd_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[GW-1:0];
                lrsd_pkg::CFG_JUMP_THRESHOLD: jump_threshold_reg <= cfg_data[LW-1:0];
                lrsd_pkg::CFG_PACKET_PAYLOAD: packet_payload_reg <= cfg_data[PW-1:0];
                default:                      frame_width_reg    <= frame_width_reg;
            endcase
        end
    end

    // Row logic: everything one pixel needs, between the input register and
    // the result register.
    always_comb
    begin
        w   = lrsd_pkg::clamp_width(frame_width_reg);
        h   = lrsd_pkg::clamp_height(frame_height_reg);
        pay = lrsd_pkg::clamp_payload(packet_payload_reg);

        // A frame start clears the counters before the pixel is used.
        cur_row        = in_start_reg ? '0 : row_reg;
        cur_col        = in_start_reg ? '0 : col_reg;
        cur_best_jump  = in_start_reg ? '0 : best_jump_reg;
        cur_best_col   = in_start_reg ? '0 : best_col_reg;
        cur_seam_total = in_start_reg ? '0 : seam_total_reg;
        cur_pq         = in_start_reg ? '0 : pix_q_reg;
        cur_pr         = in_start_reg ? '0 : pix_r_reg;
        cur_bq         = in_start_reg ? '0 : best_q_reg;
        cur_br         = in_start_reg ? '0 : best_r_reg;

        diff = (in_luma_reg >= prev_luma_reg) ? in_luma_reg - prev_luma_reg
                                              : prev_luma_reg - in_luma_reg;
        take = (cur_col >= CW'(2)) && !cur_col[0] && (diff > cur_best_jump);

        upd_jump = take ? diff    : cur_best_jump;
        upd_col  = take ? cur_col : cur_best_col;
        upd_bq   = take ? cur_pq  : cur_bq;
        upd_br   = take ? cur_pr  : cur_br;

        // Advance the tracker by the two bytes of one pixel. The payload is at
        // least eight bytes, so one conditional subtract keeps it reduced.
        r_plus = PW'(cur_pr) + PW'(2);
        wrap   = r_plus >= pay;
        step_r = wrap ? RW'(r_plus - pay) : r_plus[RW-1:0];
        step_q = cur_pq + QW'(wrap);

        col_ext     = {1'b0, cur_col};
        row_end     = (col_ext + GW'(1)) >= w;
        row_regular = (col_ext + GW'(1)) == w;
        last        = ({1'b0, cur_row} + GW'(1)) >= h;
        seam        = upd_jump > jump_threshold_reg;

        prod    = BW'(cur_row) * BW'(w);
        pos_sum = prod + BW'(upd_col);
        bp      = {pos_sum[BW-2:0], 1'b0};

        // Boundary match from the best pixel's quotient and remainder: just
        // past multiple q, or just short of multiple q + 1.
        gap        = pay - PW'(upd_br);
        match_low  = (upd_br <= RW'(lrsd_pkg::BoundarySlack)) && (upd_bq != '0)
                     && (upd_bq <= QW'(lrsd_pkg::PacketMax));
        match_high = (gap <= PW'(lrsd_pkg::BoundarySlack))
                     && (upd_bq < QW'(lrsd_pkg::PacketMax));
        if (!seam)
        begin
            pkt = '0;
        end
        else if (match_low)
        begin
            pkt = upd_bq[KW-1:0];
        end
        else if (match_high)
        begin
            pkt = upd_bq[KW-1:0] + KW'(1);
        end
        else
        begin
            pkt = '0;
        end

        seam_total_upd = (seam && (cur_seam_total != '1)) ? cur_seam_total + SW'(1)
                                                          : cur_seam_total;

        out_room = !out_valid_reg || !out_stall;
        proceed  = in_valid_reg && (rs_state_reg == lrsd_pkg::RS_IDLE)
                   && (!row_end || out_room);
        in_stall = in_valid_reg && !proceed;
        accept   = in_valid && !in_stall;

        in_valid_next = accept ? 1'b1 : (proceed ? 1'b0 : in_valid_reg);

        prev_luma_next  = prev_luma_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        best_jump_next  = best_jump_reg;
        best_col_next   = best_col_reg;
        seam_total_next = seam_total_reg;
        pix_q_next      = pix_q_reg;
        pix_r_next      = pix_r_reg;
        best_q_next     = best_q_reg;
        best_r_next     = best_r_reg;

        if (proceed)
        begin
            prev_luma_next = in_luma_reg;
            if (!row_end)
            begin
                col_next        = cur_col + CW'(1);
                row_next        = cur_row;
                best_jump_next  = upd_jump;
                best_col_next   = upd_col;
                seam_total_next = cur_seam_total;
                pix_q_next      = step_q;
                pix_r_next      = step_r;
                best_q_next     = upd_bq;
                best_r_next     = upd_br;
            end
            else
            begin
                col_next       = '0;
                best_jump_next = '0;
                best_col_next  = '0;
                if (last)
                begin
                    row_next        = '0;
                    seam_total_next = '0;
                    pix_q_next      = '0;
                    pix_r_next      = '0;
                    best_q_next     = '0;
                    best_r_next     = '0;
                end
                else
                begin
                    // The next row starts right after this pixel unless the
                    // row ran past a shrunken width; then the divider resyncs.
                    row_next        = cur_row + CW'(1);
                    seam_total_next = seam_total_upd;
                    pix_q_next      = step_q;
                    pix_r_next      = step_r;
                    best_q_next     = step_q;
                    best_r_next     = step_r;
                end
            end
        end

        out_valid_next = (proceed && row_end) ? 1'b1
                         : (out_stall ? out_valid_reg : 1'b0);

        resync = (cfg_write && (cfg_index inside {lrsd_pkg::CFG_FRAME_WIDTH,
                                                  lrsd_pkg::CFG_PACKET_PAYLOAD}))
                 || (proceed && row_end && !last && !row_regular);

        // Resync divider: load both dividends, then one quotient bit a cycle.
        load_prod     = BW'(row_reg) * BW'(w);
        load_pix_sum  = load_prod + BW'(col_reg);
        load_best_sum = load_prod + BW'(best_col_reg);

        pix_st         = lrsd_pkg::div_step(pix_rem_reg, pix_dvd_reg[BW-1], pay);
        best_st        = lrsd_pkg::div_step(best_rem_reg, best_dvd_reg[BW-1], pay);
        pix_dvd_shift  = {pix_dvd_reg[BW-2:0], pix_st.qbit};
        best_dvd_shift = {best_dvd_reg[BW-2:0], best_st.qbit};
        div_done       = div_count_reg == DCW'(lrsd_pkg::DivSteps - 1);

        rs_state_next  = rs_state_reg;
        div_count_next = div_count_reg;
        pix_dvd_next   = pix_dvd_reg;
        best_dvd_next  = best_dvd_reg;
        pix_rem_next   = pix_rem_reg;
        best_rem_next  = best_rem_reg;

        case (rs_state_reg)
            lrsd_pkg::RS_IDLE:
            begin
                rs_state_next = lrsd_pkg::RS_IDLE;
            end
            lrsd_pkg::RS_LOAD:
            begin
                pix_dvd_next   = {load_pix_sum[BW-2:0], 1'b0};
                best_dvd_next  = {load_best_sum[BW-2:0], 1'b0};
                pix_rem_next   = '0;
                best_rem_next  = '0;
                div_count_next = '0;
                rs_state_next  = lrsd_pkg::RS_DIV;
            end
            lrsd_pkg::RS_DIV:
            begin
                pix_dvd_next   = pix_dvd_shift;
                best_dvd_next  = best_dvd_shift;
                pix_rem_next   = pix_st.rem;
                best_rem_next  = best_st.rem;
                div_count_next = div_count_reg + DCW'(1);
                if (div_done)
                begin
                    pix_q_next    = pix_dvd_shift[QW-1:0];
                    pix_r_next    = pix_st.rem;
                    best_q_next   = best_dvd_shift[QW-1:0];
                    best_r_next   = best_st.rem;
                    rs_state_next = lrsd_pkg::RS_IDLE;
                end
            end
            default:
            begin
                rs_state_next = lrsd_pkg::RS_IDLE;
            end
        endcase

        if (resync)
        begin
            rs_state_next = lrsd_pkg::RS_LOAD;
        end
    end

    // Control and row state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_luma_reg  <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            best_jump_reg  <= '0;
            best_col_reg   <= '0;
            seam_total_reg <= '0;
            pix_q_reg      <= '0;
            pix_r_reg      <= '0;
            best_q_reg     <= '0;
            best_r_reg     <= '0;
            rs_state_reg   <= lrsd_pkg::RS_IDLE;
            div_count_reg  <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_luma_reg  <= prev_luma_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            best_jump_reg  <= best_jump_next;
            best_col_reg   <= best_col_next;
            seam_total_reg <= seam_total_next;
            pix_q_reg      <= pix_q_next;
            pix_r_reg      <= pix_r_next;
            best_q_reg     <= best_q_next;
            best_r_reg     <= best_r_next;
            rs_state_reg   <= rs_state_next;
            div_count_reg  <= div_count_next;
        end
    end

    // Payload registers: input item, divider datapath and result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_luma_reg  <= luma;
            in_start_reg <= frame_start;
        end
        pix_dvd_reg  <= pix_dvd_next;
        best_dvd_reg <= best_dvd_next;
        pix_rem_reg  <= pix_rem_next;
        best_rem_reg <= best_rem_next;
        if (proceed && row_end)
        begin
            row_index_reg     <= cur_row;
            seam_col_reg      <= upd_col;
            byte_position_reg <= bp;
            max_jump_reg      <= upd_jump;
            is_seam_reg       <= seam;
            on_boundary_reg   <= pkt != '0;
            packet_number_reg <= pkt;
            seam_count_reg    <= seam_total_upd;
            frame_last_reg    <= last;
        end
    end

    assign out_valid          = out_valid_reg;
    assign row_index          = row_index_reg;
    assign seam_col           = seam_col_reg;
    assign byte_position      = byte_position_reg;
    assign max_jump           = max_jump_reg;
    assign is_seam            = is_seam_reg;
    assign on_packet_boundary = on_boundary_reg;
    assign packet_number      = packet_number_reg;
    assign seam_count         = seam_count_reg;
    assign frame_last         = frame_last_reg;

    // The tracker remainder is reduced by the current payload whenever the
    // divider is not rebuilding it.
    a_tracker_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (rs_state_reg == lrsd_pkg::RS_IDLE) |-> ({1'b0, pix_r_reg} < pay))
        else $error("packet tracker remainder not reduced by payload");

    // A pixel is never consumed while the tracker is being rebuilt.
    a_no_process_in_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (rs_state_reg == lrsd_pkg::RS_DIV) |-> !proceed)
        else $error("pixel processed during tracker resync");

    // A boundary match always names a packet, and only seam rows match.
    a_boundary_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((on_packet_boundary == (packet_number != '0))
                       && (is_seam || !on_packet_boundary)))
        else $error("inconsistent packet boundary result");

    // A seam row is counted in its own result.
    a_seam_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_seam) |-> (seam_count != '0))
        else $error("seam row not counted");

endmodule

### sim/luma_row_seam_detector_unit_test.sv
// Self-checking testbench for luma_row_seam_detector_unit: streams pixels, predicts each
// row result in place and compares every result transfer with the oldest prediction.
// Depends on lrsd_pkg and the block's RTL; needs no files or arguments.
module luma_row_seam_detector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lrsd_pkg::*;

    // Extra cycles waited once every predicted row has come back, before the block counts
    // as idle. This covers the packet tracker restart that follows a width or payload
    // write, or a row ending past a shrunken width.
    localparam int SettleCycles = 40;

    // One row result, fields in the order of the output ports.
    typedef struct packed {
        logic [CoordWidth-1:0]   row;
        logic [CoordWidth-1:0]   col;
        logic [BytePosWidth-1:0] byte_pos;
        logic [LumaWidth-1:0]    jump;
        logic                    seam;
        logic                    boundary;
        logic [PacketWidth-1:0]  packet;
        logic [CountWidth-1:0]   count;
        logic                    last;
    } row_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [LumaWidth-1:0]      luma = '0;
    logic                      frame_start = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [CoordWidth-1:0]     row_index;
    logic [CoordWidth-1:0]     seam_col;
    logic [BytePosWidth-1:0]   byte_position;
    logic [LumaWidth-1:0]      max_jump;
    logic                      is_seam;
    logic                      on_packet_boundary;
    logic [PacketWidth-1:0]    packet_number;
    logic [CountWidth-1:0]     seam_count;
    logic                      frame_last;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    cfg_reg_t                  cfg_index = CFG_FRAME_WIDTH;
    logic [CfgDataWidth-1:0]   cfg_data = '0;

    luma_row_seam_detector_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .luma               (luma),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .row_index          (row_index),
        .seam_col           (seam_col),
        .byte_position      (byte_position),
        .max_jump           (max_jump),
        .is_seam            (is_seam),
        .on_packet_boundary (on_packet_boundary),
        .packet_number      (packet_number),
        .seam_count         (seam_count),
        .frame_last         (frame_last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Register copies as the block holds them, before clamping.
    logic [GeomWidth-1:0]    width_reg;
    logic [GeomWidth-1:0]    height_reg;
    logic [LumaWidth-1:0]    thresh_reg;
    logic [PayloadWidth-1:0] payload_reg;

    // Row scanning state of the predictor.
    logic [LumaWidth-1:0]    last_luma;
    int unsigned             row_ctr;
    int unsigned             col_ctr;
    int unsigned             best_jump;
    int unsigned             best_col;
    int unsigned             seam_total;

    row_result_t             expected_rows[$];
    int                      mismatch_count = 0;
    int unsigned             pixels_sent = 0;

    // Largest idle stretch of each side, changed from phase to phase.
    int unsigned             tx_gap_max = 0;
    int unsigned             rx_wait_max = 0;
    int unsigned             rx_wait = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // A generous ceiling on the whole run; a hang anywhere ends here.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic string show_row(input row_result_t r);
        return $sformatf("row=%0d col=%0d byte=%0d jump=%0d seam=%0b bnd=%0b pkt=%0d cnt=%0d last=%0b",
                         r.row, r.col, r.byte_pos, r.jump, r.seam, r.boundary, r.packet,
                         r.count, r.last);
    endfunction

    // Idle stretch limit for one phase: none, short or the longest.
    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    // Luma source mixing the two extremes, small steps near the previous value,
    // which give jumps around typical thresholds, and fully random values.
    function automatic logic [LumaWidth-1:0] next_luma(input logic [LumaWidth-1:0] prev);
        int v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 255;
            2, 3, 4: v = int'(prev) + int'($urandom_range(0, 20)) - 10;
            default: v = int'($urandom_range(0, 255));
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return LumaWidth'(v);
    endfunction

    // Advances the predictor by one accepted pixel. When the pixel closes a row, the
    // row's result is appended to the queue of expected results.
    task automatic predict_pixel(input logic [LumaWidth-1:0] y, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned pay;
        int unsigned diff;
        int unsigned bp;
        int unsigned q;
        int unsigned r;
        row_result_t res;
        w   = clip(width_reg, MinWidth, MaxWidth);
        h   = clip(height_reg, MinHeight, MaxHeight);
        pay = clip(payload_reg, MinPayload, MaxPayload);
        if (fs) begin
            row_ctr    = 0;
            col_ctr    = 0;
            best_jump  = 0;
            best_col   = 0;
            seam_total = 0;
        end
        // Only even columns from 2 upward compare against the pixel before them.
        if (col_ctr >= 2 && (col_ctr % 2) == 0) begin
            diff = (y >= last_luma) ? int'(y) - int'(last_luma) : int'(last_luma) - int'(y);
            if (diff > best_jump) begin
                best_jump = diff;
                best_col  = col_ctr;
            end
        end
        last_luma = y;
        // A column counter at or past the last column ends the row, which also
        // covers a width that shrank in the middle of a row.
        if (col_ctr + 1 < w) begin
            col_ctr++;
            return;
        end
        res          = '0;
        bp           = 2 * (row_ctr * w + best_col);
        res.row      = CoordWidth'(row_ctr);
        res.col      = CoordWidth'(best_col);
        res.byte_pos = BytePosWidth'(bp);
        res.jump     = LumaWidth'(best_jump);
        res.seam     = best_jump > thresh_reg;
        res.last     = row_ctr + 1 >= h;
        // Only a seam row looks for a packet boundary; the smaller multiple wins.
        if (res.seam) begin
            q = bp / pay;
            r = bp % pay;
            if (r <= BoundarySlack && q >= 1 && q <= PacketMax) begin
                res.packet   = PacketWidth'(q);
                res.boundary = 1'b1;
            end else if (pay - r <= BoundarySlack && q + 1 <= PacketMax) begin
                res.packet   = PacketWidth'(q + 1);
                res.boundary = 1'b1;
            end
            if (seam_total < 2047) seam_total++;
        end
        res.count = CountWidth'(seam_total);
        expected_rows.push_back(res);
        col_ctr   = 0;
        best_jump = 0;
        best_col  = 0;
        if (res.last) begin
            row_ctr    = 0;
            seam_total = 0;
        end else begin
            row_ctr++;
        end
    endtask

    // Offers one pixel after a random gap and returns at the edge of its transfer.
    // Valid stays high from one pixel to the next when no gap is drawn.
    task automatic send_pixel(input logic [LumaWidth-1:0] y, input logic fs);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        luma        <= y;
        frame_start <= fs;
        do @(posedge clk); while (in_stall);
        predict_pixel(y, fs);
        pixels_sent++;
    endtask

    // Writes one register and mirrors the write, with the register's own width,
    // into the predictor.
    task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataWidth-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:    width_reg   = data[GeomWidth-1:0];
            CFG_FRAME_HEIGHT:   height_reg  = data[GeomWidth-1:0];
            CFG_JUMP_THRESHOLD: thresh_reg  = data[LumaWidth-1:0];
            CFG_PACKET_PAYLOAD: payload_reg = data[PayloadWidth-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drops valid and waits until every predicted row has been received, then for
    // a number of extra cycles; with extra cycles the block is idle afterwards.
    task automatic settle_block(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // The receiver holds stall high for the number of cycles drawn at the previous
    // result transfer, then lowers it until the next transfer.
    always @(negedge clk) begin
        if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Every result transfer is compared with the oldest prediction, all fields at once;
    // a transfer with nothing predicted is a failure as well.
    always @(posedge clk) begin : check_rows
        row_result_t got;
        row_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = {row_index, seam_col, byte_position, max_jump, is_seam,
                   on_packet_boundary, packet_number, seam_count, frame_last};
            if (expected_rows.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected row result: %s", show_row(got));
            end else begin
                want = expected_rows.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("row result mismatch: expected %s, got %s",
                                 show_row(want), show_row(got));
                end
            end
            rx_wait = $urandom_range(0, rx_wait_max);
        end
    end

    // A 4 x 3 frame under the reset threshold and payload. The first row has a full
    // scale jump, the second row is flat so it has no jump at all and reports the
    // row's first byte, and the third row is a seam on the last row of the frame.
    task automatic test_directed_rows();
        tx_gap_max  = 3;
        rx_wait_max = 3;
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        repeat (4) send_pixel(8'd255, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd60, 1'b0);
        send_pixel(8'd60, 1'b0);
    endtask

    // After the frame end the counters start over without a frame_start; a
    // frame_start in the middle of that row then clears everything again.
    task automatic test_frame_resync();
        send_pixel(8'd5, 1'b0);
        send_pixel(8'd6, 1'b0);
        send_pixel(8'd7, 1'b1);
        repeat (3) send_pixel(8'd9, 1'b0);
    endtask

    // The width shrinks while a row is open, so the next pixel ends that row; then
    // the height shrinks below the current row, so the next row ends the frame.
    task automatic test_geometry_shrink();
        send_pixel(8'd40, 1'b0);
        send_pixel(8'd41, 1'b0);
        send_pixel(8'd42, 1'b0);
        settle_block(SettleCycles);
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        send_pixel(8'd200, 1'b0);
        settle_block(SettleCycles);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
    endtask

    // One full row at the widest geometry: the width is written out of range so it
    // saturates, the height and payload at their maxima and the threshold at 255.
    task automatic test_widest_row();
        int k;
        settle_block(SettleCycles);
        write_reg(CFG_FRAME_WIDTH, 13'd2047);
        write_reg(CFG_FRAME_HEIGHT, 13'd1024);
        write_reg(CFG_JUMP_THRESHOLD, 13'd255);
        write_reg(CFG_PACKET_PAYLOAD, 13'd4096);
        tx_gap_max  = 0;
        rx_wait_max = 12;
        for (k = 0; k < 1026; k++) begin
            send_pixel(LumaWidth'($urandom_range(0, 255)), k == 0);
        end
    endtask

    // Random phases: each one settles the block, draws a new setting and idle
    // limits, then streams a frame-like run of pixels. Most runs open with a
    // frame_start, a few frame_starts land anywhere as noise, and now and then the
    // sender waits until every predicted row has come back.
    task automatic test_random_frames(input int unsigned item_target);
        int unsigned goal;
        int unsigned n;
        int unsigned k;
        logic [CfgDataWidth-1:0] data;
        logic [LumaWidth-1:0] y;
        goal = pixels_sent + item_target;
        y    = '0;
        while (pixels_sent < goal) begin
            settle_block(SettleCycles);
            tx_gap_max  = pick_gap();
            rx_wait_max = pick_gap();
            // Small widths keep rows short; bit 11 set shows the 11-bit register cut.
            case ($urandom_range(0, 9))
                0:       data = CfgDataWidth'($urandom_range(0, 1));
                1:       data = CfgDataWidth'($urandom_range(13, 64));
                2:       data = 13'h0800 | CfgDataWidth'($urandom_range(2, 10));
                default: data = CfgDataWidth'($urandom_range(2, 12));
            endcase
            write_reg(CFG_FRAME_WIDTH, data);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = 13'd1024;
                    2:       data = 13'h1FFF;
                    3:       data = 13'h0800 | CfgDataWidth'($urandom_range(1, 6));
                    default: data = CfgDataWidth'($urandom_range(1, 8));
                endcase
                write_reg(CFG_FRAME_HEIGHT, data);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = 13'd255;
                    2:       data = 13'h1F00 | CfgDataWidth'($urandom_range(0, 255));
                    default: data = CfgDataWidth'($urandom_range(0, 255));
                endcase
                write_reg(CFG_JUMP_THRESHOLD, data);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0:       data = CfgDataWidth'($urandom_range(0, 7));
                    1:       data = 13'd4096;
                    2:       data = CfgDataWidth'($urandom_range(4097, 8191));
                    default: data = CfgDataWidth'($urandom_range(8, 48));
                endcase
                write_reg(CFG_PACKET_PAYLOAD, data);
            end
            n = $urandom_range(30, 90);
            for (k = 0; k < n; k++) begin
                if (k > 0 && $urandom_range(0, 15) == 0) settle_block(0);
                y = next_luma(y);
                if (k == 0) begin
                    send_pixel(y, $urandom_range(0, 3) != 0);
                end else begin
                    send_pixel(y, $urandom_range(0, 49) == 0);
                end
            end
        end
    endtask

    initial begin : main
        int wait_cycles;
        // Predictor state after reset matches the block's register defaults.
        width_reg   = GeomWidth'(ResetWidth);
        height_reg  = GeomWidth'(ResetHeight);
        thresh_reg  = LumaWidth'(ResetThresh);
        payload_reg = PayloadWidth'(ResetPayload);
        last_luma   = '0;
        row_ctr     = 0;
        col_ctr     = 0;
        best_jump   = 0;
        best_col    = 0;
        seam_total  = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_rows();
        test_frame_resync();
        test_geometry_shrink();
        test_widest_row();
        test_random_frames(1000);

        // Let the last results drain, with a bound so a lost result still ends here.
        @(negedge clk);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_rows.size() != 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SettleCycles) @(posedge clk);

        if (mismatch_count == 0 && expected_rows.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/lrsd_pkg.sv
rtl/core/luma_row_seam_detector_unit.sv
sim/luma_row_seam_detector_unit_test.sv
